// ===== design/rti_pkg.sv =====
package rti_pkg;

    localparam int MAX_TRIANGLES = 64;
    localparam int COORD_W       = 32;
    localparam int FRAC_BITS     = 16;
    localparam int VERTS_PER_TRI = 3;
    localparam int SLOTS         = VERTS_PER_TRI * MAX_TRIANGLES;
    localparam int SLOT_W        = 8;
    localparam int TRI_W         = $clog2(MAX_TRIANGLES);
    localparam int CNT_W         = 7;

    // vertex + offset - origin, exact
    localparam int VTX_W  = COORD_W + 2;
    // multiplier operand: one vertex or direction component, or one limb of a cross component
    localparam int OPW    = VTX_W + 1;
    localparam int LIMB_W = VTX_W;
    // cross product component of two vertex vectors
    localparam int CRS_W  = 2 * VTX_W + 1;
    // triple products and their sum
    localparam int ACC_W  = 2 * VTX_W + CRS_W + 1;
    // quotient magnitude bits below the sign
    localparam int Q_W    = COORD_W - 1;
    localparam int SAT_SH = Q_W - FRAC_BITS;

    typedef enum logic [1:0] {
        CFG_TRI_COUNT = 2'd0,
        CFG_OFFSET_X  = 2'd1,
        CFG_OFFSET_Y  = 2'd2,
        CFG_OFFSET_Z  = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_RAY  = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic                      req_type;
        logic [SLOT_W-1:0]         vertex_slot;
        logic signed [COORD_W-1:0] vert_x;
        logic signed [COORD_W-1:0] vert_y;
        logic signed [COORD_W-1:0] vert_z;
        logic signed [COORD_W-1:0] ray_org_x;
        logic signed [COORD_W-1:0] ray_org_y;
        logic signed [COORD_W-1:0] ray_org_z;
        logic signed [COORD_W-1:0] ray_dir_x;
        logic signed [COORD_W-1:0] ray_dir_y;
        logic signed [COORD_W-1:0] ray_dir_z;
    } req_t;

    typedef struct packed {
        logic [TRI_W-1:0]          tri_index;
        logic                      hit;
        logic signed [COORD_W-1:0] ray_param;
        logic                      parallel;
        logic                      last;
    } res_t;

    typedef logic [2:0][COORD_W-1:0] vtx_t;

    typedef enum logic [1:0] {
        DST_NONE  = 2'd0,
        DST_CROSS = 2'd1,
        DST_G     = 2'd2,
        DST_NUM   = 2'd3
    } mac_dst_t;

    typedef struct packed {
        logic       en;
        logic       hi;
        logic       sub;
        logic       clr;
        mac_dst_t   dst;
        logic [1:0] vec;
        logic [1:0] axis;
    } mac_op_t;

    function automatic logic [1:0] nxt3(input logic [1:0] x);
        logic [1:0] r;
        case (x)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [VTX_W-1:0] ext_v(input logic [COORD_W-1:0] x);
        return {{(VTX_W - COORD_W){x[COORD_W-1]}}, x};
    endfunction

endpackage

// ===== design/ray_triangle_intersect_core.sv =====
// Ray / triangle intersection core. A load request writes one vertex (three consecutive
// slots per triangle). A ray request tests the ray against the first triangle_count
// stored triangles (at most MAX_TRIANGLES) and returns one result per triangle in index
// order, the last one flagged. Each triangle fetches its vertices from the vertex memory
// (one read port, one slot per cycle), passes through the single 35x35 multiply-accumulate
// unit that forms three cross products and four triple products, settles the sums, runs
// the shared restoring divider (one quotient bit per cycle, skipped for a parallel ray and
// shortened when t saturates) and hands off the result. The core takes no request while a
// ray is in progress. Results go out through a holding register, so a stalled result costs
// one triangle of overlap at most. The edge tests use the exact triple products
// D.((Va-O) x (Vb-O)), so hit and t agree bit for bit with exact arithmetic. Reading a
// vertex slot that was never loaded returns undefined data.
module ray_triangle_intersect_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  rti_pkg::req_t                 req_data,
    output logic                          res_valid,
    input  logic                          res_stall,
    output rti_pkg::res_t                 res_data,
    input  logic                          cfg_we,
    input  rti_pkg::cfg_idx_t             cfg_index,
    input  logic [rti_pkg::COORD_W-1:0]   cfg_data
);
    import rti_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FETCH = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_DRAIN = 8'b0000_1000,
        S_SUM   = 8'b0001_0000,
        S_DEC   = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    localparam logic [CNT_W-1:0]   MAX_CNT = CNT_W'(MAX_TRIANGLES);
    localparam logic [COORD_W-1:0] T_MAX   = {1'b0, {Q_W{1'b1}}};

    // configuration
    logic [CNT_W-1:0]   tri_count_reg;
    logic [COORD_W-1:0] off_reg [3];

    // sequencer
    state_t             state_reg, state_next;
    logic [1:0]         fc_reg, fc_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [TRI_W-1:0]   tri_reg, tri_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               dot_reg, dot_next;
    logic [1:0]         grp_reg, grp_next;
    logic [1:0]         axis_reg, axis_next;
    logic               term_reg, term_next;

    // per ray / per triangle operands and products
    logic [COORD_W-1:0]      org_reg [3];
    logic [COORD_W-1:0]      dir_reg [3];
    logic signed [VTX_W-1:0] v_reg   [3][3];
    logic signed [CRS_W-1:0] crs_reg [3][3];
    logic signed [ACC_W-1:0] g_reg   [3];
    logic signed [ACC_W-1:0] num_reg;
    logic signed [ACC_W-1:0] den_reg;
    logic                    hit_reg;
    logic                    par_reg;
    logic [COORD_W-1:0]      t_reg;

    // vertex memory
    vtx_t               mem [SLOTS];
    vtx_t               rd_data_reg;
    logic               mem_we;
    logic               mem_re;

    // results
    logic               res_valid_reg, res_valid_next;
    res_t               res_reg;
    logic               res_load;
    logic               last_tri;

    // shared multiply-accumulate
    mac_op_t                 mac_op;
    mac_op_t                 mac_wb;
    logic signed [OPW-1:0]   opa;
    logic signed [OPW-1:0]   opb;
    logic signed [ACC_W-1:0] mac_data;
    logic [1:0]              a1, a2, nv, cv;
    logic [1:0]              cap;

    // divider
    logic               div_start;
    logic               div_done;
    logic [COORD_W-1:0] div_quo;

    logic               req_accept;
    logic               all_pos;
    logic               all_neg;

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign res_valid  = res_valid_reg;
    assign res_data   = res_reg;

    assign last_tri = ({1'b0, tri_reg} + CNT_W'(1)) == cnt_reg;
    assign cap      = fc_reg - 2'd1;
    assign mem_we   = req_accept && (req_data.req_type == REQ_LOAD)
                      && (req_data.vertex_slot < SLOT_W'(SLOTS));
    assign mem_re   = (state_reg == S_FETCH) && (fc_reg != 2'd3);
    assign res_load = (state_reg == S_OUT) && (!res_valid_reg || !res_stall);
    assign div_start = (state_reg == S_DEC) && (den_reg != '0);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tri_count_reg <= CNT_W'(1);
            off_reg       <= '{default: '0};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TRI_COUNT: tri_count_reg <= cfg_data[CNT_W-1:0];
                CFG_OFFSET_X:  off_reg[0]    <= cfg_data;
                CFG_OFFSET_Y:  off_reg[1]    <= cfg_data;
                CFG_OFFSET_Z:  off_reg[2]    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Vertex memory: write on load requests, read the three slots of a triangle during fetch
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[req_data.vertex_slot] <= {req_data.vert_z, req_data.vert_y, req_data.vert_x};
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[slot_reg];
        end
    end

    // Issue one multiply per cycle. Cross phase: C[j] = V[j] x V[j+1], two terms per
    // component. Dot phase: g[j] = D.C[j] and num = V0.C1, each component split into a
    // low limb and a signed high limb.
    always_comb
    begin
        mac_op = '0;
        opa    = '0;
        opb    = '0;
        a1     = nxt3(axis_reg);
        a2     = nxt3(a1);
        nv     = nxt3(grp_reg);
        cv     = (grp_reg == 2'd3) ? 2'd1 : grp_reg;
        if (state_reg == S_MUL)
        begin
            mac_op.en   = 1'b1;
            mac_op.vec  = grp_reg;
            mac_op.axis = axis_reg;
            if (!dot_reg)
            begin
                if (!term_reg)
                begin
                    opa        = {v_reg[grp_reg][a1][VTX_W-1], v_reg[grp_reg][a1]};
                    opb        = {v_reg[nv][a2][VTX_W-1], v_reg[nv][a2]};
                    mac_op.clr = 1'b1;
                end
                else
                begin
                    opa        = {v_reg[grp_reg][a2][VTX_W-1], v_reg[grp_reg][a2]};
                    opb        = {v_reg[nv][a1][VTX_W-1], v_reg[nv][a1]};
                    mac_op.sub = 1'b1;
                    mac_op.dst = DST_CROSS;
                end
            end
            else
            begin
                if (grp_reg == 2'd3)
                begin
                    opa = {v_reg[0][axis_reg][VTX_W-1], v_reg[0][axis_reg]};
                end
                else
                begin
                    opa = OPW'(signed'(dir_reg[axis_reg]));
                end
                if (term_reg)
                begin
                    opb = crs_reg[cv][axis_reg][CRS_W-1:LIMB_W];
                end
                else
                begin
                    opb = {1'b0, crs_reg[cv][axis_reg][LIMB_W-1:0]};
                end
                mac_op.hi  = term_reg;
                mac_op.clr = (axis_reg == 2'd0) && !term_reg;
                if (axis_reg == 2'd2 && term_reg)
                begin
                    mac_op.dst = (grp_reg == 2'd3) ? DST_NUM : DST_G;
                end
            end
        end
    end

    rti_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (mac_op),
        .opa     (opa),
        .opb     (opb),
        .wb      (mac_wb),
        .wb_data (mac_data)
    );

    rti_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        fc_next    = fc_reg;
        slot_next  = slot_reg;
        tri_next   = tri_reg;
        cnt_next   = cnt_reg;
        dot_next   = dot_reg;
        grp_next   = grp_reg;
        axis_next  = axis_reg;
        term_next  = term_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_accept && req_data.req_type == REQ_RAY)
                begin
                    cnt_next  = (tri_count_reg > MAX_CNT) ? MAX_CNT : tri_count_reg;
                    tri_next  = '0;
                    slot_next = '0;
                    fc_next   = '0;
                    if (tri_count_reg != '0)
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                fc_next = fc_reg + 2'd1;
                if (mem_re)
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
                if (fc_reg == 2'd3)
                begin
                    dot_next   = 1'b0;
                    grp_next   = '0;
                    axis_next  = '0;
                    term_next  = 1'b0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                term_next = !term_reg;
                if (term_reg)
                begin
                    axis_next = nxt3(axis_reg);
                    if (axis_reg == 2'd2)
                    begin
                        grp_next = grp_reg + 2'd1;
                        if (!dot_reg && grp_reg == 2'd2)
                        begin
                            dot_next = 1'b1;
                            grp_next = '0;
                        end
                        if (dot_reg && grp_reg == 2'd3)
                        begin
                            state_next = S_DRAIN;
                        end
                    end
                end
            end
            S_DRAIN:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                state_next = (den_reg == '0) ? S_OUT : S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (res_load)
                begin
                    if (last_tri)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        tri_next   = tri_reg + TRI_W'(1);
                        fc_next    = '0;
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_load || (res_valid_reg && res_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fc_reg        <= '0;
            slot_reg      <= '0;
            tri_reg       <= '0;
            cnt_reg       <= '0;
            dot_reg       <= 1'b0;
            grp_reg       <= '0;
            axis_reg      <= '0;
            term_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fc_reg        <= fc_next;
            slot_reg      <= slot_next;
            tri_reg       <= tri_next;
            cnt_reg       <= cnt_next;
            dot_reg       <= dot_next;
            grp_reg       <= grp_next;
            axis_reg      <= axis_next;
            term_reg      <= term_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Edge test: every triple product must be nonzero and share the sign of their sum
    always_comb
    begin
        all_pos = 1'b1;
        all_neg = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            if (g_reg[k][ACC_W-1] || g_reg[k] == '0)
            begin
                all_pos = 1'b0;
            end
            if (!g_reg[k][ACC_W-1])
            begin
                all_neg = 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (req_accept && req_data.req_type == REQ_RAY)
        begin
            org_reg[0] <= req_data.ray_org_x;
            org_reg[1] <= req_data.ray_org_y;
            org_reg[2] <= req_data.ray_org_z;
            dir_reg[0] <= req_data.ray_dir_x;
            dir_reg[1] <= req_data.ray_dir_y;
            dir_reg[2] <= req_data.ray_dir_z;
        end

        // Shift each fetched vertex by the object offset, relative to the origin
        if (state_reg == S_FETCH && fc_reg != 2'd0)
        begin
            for (int k = 0; k < 3; k++)
            begin
                v_reg[cap][k] <= ext_v(rd_data_reg[k]) + ext_v(off_reg[k])
                                 - ext_v(org_reg[k]);
            end
        end

        if (mac_wb.en)
        begin
            case (mac_wb.dst)
                DST_CROSS: crs_reg[mac_wb.vec][mac_wb.axis] <= mac_data[CRS_W-1:0];
                DST_G:     g_reg[mac_wb.vec]                <= mac_data;
                DST_NUM:   num_reg                          <= mac_data;
                default:   ;
            endcase
        end

        if (state_reg == S_SUM)
        begin
            den_reg <= g_reg[0] + g_reg[1] + g_reg[2];
        end

        if (state_reg == S_DEC)
        begin
            par_reg <= (den_reg == '0);
            hit_reg <= (den_reg != '0) && (den_reg[ACC_W-1] ? all_neg : all_pos);
            t_reg   <= T_MAX;
        end

        if (state_reg == S_DIV && div_done)
        begin
            t_reg <= div_quo;
        end

        if (res_load)
        begin
            res_reg.tri_index <= tri_reg;
            res_reg.hit       <= hit_reg;
            res_reg.ray_param <= t_reg;
            res_reg.parallel  <= par_reg;
            res_reg.last      <= last_tri;
        end
    end

endmodule

// ===== design/rti_mac.sv =====
module rti_mac (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rti_pkg::mac_op_t                op,
    input  logic signed [rti_pkg::OPW-1:0]  opa,
    input  logic signed [rti_pkg::OPW-1:0]  opb,
    output rti_pkg::mac_op_t                wb,
    output logic signed [rti_pkg::ACC_W-1:0] wb_data
);
    import rti_pkg::*;

    logic signed [2*OPW-1:0] prod_reg;
    mac_op_t                 op_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] addend;

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
        if (op_reg.en)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= '0;
        end
        else
        begin
            op_reg <= op;
        end
    end

    always_comb
    begin
        addend = ACC_W'(prod_reg);
        if (op_reg.hi)
        begin
            addend = addend <<< LIMB_W;
        end
        acc_next = (op_reg.clr ? '0 : acc_reg) + (op_reg.sub ? -addend : addend);
    end

    always_comb
    begin
        wb    = op_reg;
        wb.en = op_reg.en && (op_reg.dst != DST_NONE);
    end

    assign wb_data = acc_next;

endmodule

// ===== design/rti_div.sv =====
module rti_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [rti_pkg::ACC_W-1:0] num,
    input  logic signed [rti_pkg::ACC_W-1:0] den,
    output logic                             done,
    output logic [rti_pkg::COORD_W-1:0]      quo
);
    import rti_pkg::*;

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_CHK  = 3'b010,
        D_RUN  = 3'b100
    } div_state_t;

    localparam logic [COORD_W-1:0] T_MAX = {1'b0, {Q_W{1'b1}}};
    localparam logic [COORD_W-1:0] T_MIN = {1'b1, {Q_W{1'b0}}};

    div_state_t             state_reg;
    logic [ACC_W-1:0]       nmag_reg;
    logic [ACC_W-1:0]       dmag_reg;
    logic                   neg_reg;
    logic [ACC_W-1:0]       rem_reg;
    logic [Q_W-1:0]         sh_reg;
    logic [Q_W-1:0]         q_reg;
    logic [4:0]             cnt_reg;
    logic                   done_reg;
    logic [COORD_W-1:0]     quo_reg;

    logic [ACC_W:0]         trial;
    logic                   qbit;
    logic [Q_W-1:0]         q_fin;
    logic                   sat;

    always_comb
    begin
        trial = {rem_reg, sh_reg[Q_W-1]};
        qbit  = trial >= {1'b0, dmag_reg};
        q_fin = {q_reg[Q_W-2:0], qbit};
        sat   = {{SAT_SH{1'b0}}, nmag_reg} >= {dmag_reg, {SAT_SH{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= D_CHK;
                    end
                end
                D_CHK:
                begin
                    if (sat)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                    else
                    begin
                        cnt_reg   <= 5'(Q_W - 1);
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && start)
        begin
            nmag_reg <= num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
            dmag_reg <= den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
            neg_reg  <= num[ACC_W-1] ^ den[ACC_W-1];
        end
        if (state_reg == D_CHK)
        begin
            quo_reg <= neg_reg ? T_MIN : T_MAX;
            rem_reg <= nmag_reg >> SAT_SH;
            sh_reg  <= {nmag_reg[SAT_SH-1:0], {FRAC_BITS{1'b0}}};
            q_reg   <= '0;
        end
        if (state_reg == D_RUN)
        begin
            rem_reg <= qbit ? ACC_W'(trial - {1'b0, dmag_reg}) : ACC_W'(trial);
            sh_reg  <= {sh_reg[Q_W-2:0], 1'b0};
            q_reg   <= q_fin;
            if (cnt_reg == 5'd0)
            begin
                quo_reg <= neg_reg ? -{1'b0, q_fin} : {1'b0, q_fin};
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import rti_pkg::*;

    // Exact arithmetic: the edge terms need about 250 bits, so keep some headroom.
    typedef logic signed [383:0] wide_t;
    typedef struct packed {
        wide_t x;
        wide_t y;
        wide_t z;
    } vec_t;

    // One row of the directed table: the request, and optionally a typed-in result.
    typedef struct {
        req_t r;
        bit   typed;
        res_t e;
    } row_t;

    localparam logic [31:0] Q_ONE   = 32'h0001_0000;
    localparam logic [31:0] Q_QTR   = 32'h0000_4000;
    localparam logic [31:0] Q_MONE  = 32'hFFFF_0000;
    localparam logic [31:0] C_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] C_MIN   = 32'h8000_0000;
    localparam int          LIMIT   = 10_000_000;
    localparam int          SETTLE  = 300;
    localparam int          HOLD_CYCLES = 3000;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    req_t       req_data;
    logic       res_valid;
    logic       res_stall;
    res_t       res_data;
    logic       cfg_we;
    cfg_idx_t   cfg_index;
    logic [31:0] cfg_data;

    // Shadow of the block state, updated as requests are accepted.
    logic [31:0] vx_mem [SLOTS];
    logic [31:0] vy_mem [SLOTS];
    logic [31:0] vz_mem [SLOTS];
    logic [6:0]  tri_cnt;
    logic [31:0] off_x, off_y, off_z;

    res_t expected_hits [$];
    int   errors;
    int   cycles;
    int   hold_left;
    int   hold_req;
    int   hold_ack;
    int   stall_mode;
    int   stall_timer;
    bit   no_gaps;

    ray_triangle_intersect_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------------
    // Exact geometry
    // ---------------------------------------------------------------------
    function automatic vec_t vsub(vec_t a, vec_t b);
        vec_t r;
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        r.z = a.z - b.z;
        return r;
    endfunction

    function automatic vec_t vcross(vec_t a, vec_t b);
        wide_t ax, ay, az, bx, by, bz;
        vec_t  r;
        ax = a.x; ay = a.y; az = a.z;
        bx = b.x; by = b.y; bz = b.z;
        r.x = ay * bz - az * by;
        r.y = az * bx - ax * bz;
        r.z = ax * by - ay * bx;
        return r;
    endfunction

    function automatic wide_t vdot(vec_t a, vec_t b);
        wide_t ax, ay, az, bx, by, bz;
        ax = a.x; ay = a.y; az = a.z;
        bx = b.x; by = b.y; bz = b.z;
        return ax * bx + ay * by + az * bz;
    endfunction

    function automatic vec_t coord_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        vec_t r;
        r.x = wide_t'($signed(x));
        r.y = wide_t'($signed(y));
        r.z = wide_t'($signed(z));
        return r;
    endfunction

    // Stored vertex shifted by the object offset, kept exact.
    function automatic vec_t placed_vertex(int b);
        vec_t r;
        r.x = wide_t'($signed(vx_mem[b])) + wide_t'($signed(off_x));
        r.y = wide_t'($signed(vy_mem[b])) + wide_t'($signed(off_y));
        r.z = wide_t'($signed(vz_mem[b])) + wide_t'($signed(off_z));
        return r;
    endfunction

    // t = num/den in Q16.16, truncated toward zero, saturated to 32 bits.
    function automatic logic [31:0] plane_param(wide_t num, wide_t den);
        wide_t num_m, den_m, q, lim;
        bit    neg;
        num_m = num < 0 ? -num : num;
        den_m = den < 0 ? -den : den;
        q     = (num_m <<< FRAC_BITS) / den_m;
        lim   = wide_t'(C_MAX);
        neg   = (num < 0) != (den < 0);
        if (!neg)
            return q > lim ? C_MAX : q[31:0];
        if (q > lim + 1)
            q = lim + 1;
        return 32'(-q);
    endfunction

    // Test one ray against every triangle in use; queue one result per triangle.
    function automatic void cast_ray(req_t r);
        vec_t  org, dir, n, s[3], v[3];
        wide_t num, den, a;
        res_t  e;
        int    eff, sd;
        org = coord_vec(r.ray_org_x, r.ray_org_y, r.ray_org_z);
        dir = coord_vec(r.ray_dir_x, r.ray_dir_y, r.ray_dir_z);
        eff = tri_cnt > MAX_TRIANGLES ? MAX_TRIANGLES : tri_cnt;
        for (int k = 0; k < eff; k++) begin
            for (int j = 0; j < 3; j++)
                v[j] = placed_vertex(k * VERTS_PER_TRI + j);
            s[0] = vsub(v[1], v[0]);
            s[1] = vsub(v[2], v[1]);
            s[2] = vsub(v[0], v[2]);
            n    = vcross(s[0], vsub(v[2], v[0]));
            num  = vdot(n, vsub(v[0], org));
            den  = vdot(n, dir);
            sd   = den < 0 ? -1 : (den == 0 ? 0 : 1);
            e.tri_index = TRI_W'(k);
            e.last      = (k + 1 == eff);
            if (sd == 0) begin
                e.parallel  = 1'b1;
                e.hit       = 1'b0;
                e.ray_param = C_MAX;
            end else begin
                e.parallel = 1'b0;
                e.hit      = 1'b1;
                // Keep t as the fraction num/den so each edge sign is exact.
                for (int j = 0; j < 3; j++) begin
                    a = vdot(n, vcross(s[j], vsub(org, v[j]))) * den
                      + vdot(n, vcross(s[j], dir)) * num;
                    if (a == 0 || ((a < 0) != (sd < 0)))
                        e.hit = 1'b0;
                end
                e.ray_param = plane_param(num, den);
            end
            expected_hits = {expected_hits, e};
        end
    endfunction

    function automatic void track_request(req_t r);
        if (r.req_type == REQ_LOAD) begin
            // Slots past the table are dropped by the block.
            if (r.vertex_slot < SLOTS) begin
                vx_mem[r.vertex_slot] = r.vert_x;
                vy_mem[r.vertex_slot] = r.vert_y;
                vz_mem[r.vertex_slot] = r.vert_z;
            end
        end else begin
            cast_ray(r);
        end
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    function automatic req_t make_req(req_kind_t kind, int slot,
                                      logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                      logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                      logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        req_t r;
        r.req_type    = kind;
        r.vertex_slot = SLOT_W'(slot);
        r.vert_x = x;    r.vert_y = y;    r.vert_z = z;
        r.ray_org_x = ox; r.ray_org_y = oy; r.ray_org_z = oz;
        r.ray_dir_x = dx; r.ray_dir_y = dy; r.ray_dir_z = dz;
        return r;
    endfunction

    function automatic res_t make_res(int idx, bit hit, logic [31:0] t, bit par, bit last);
        res_t e;
        e.tri_index = TRI_W'(idx);
        e.hit       = hit;
        e.ray_param = t;
        e.parallel  = par;
        e.last      = last;
        return e;
    endfunction

    function automatic logic [31:0] rand_small(int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [31:0] rand_coord();
        return ($urandom_range(0, 9) < 7) ? rand_small(1 << 20) : $urandom;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_gaps || p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Ray aimed near the centroid of a triangle in use, from a nearby origin.
    function automatic req_t aimed_ray();
        longint p[3], o[3], d[3];
        int     k, eff, b;
        vec_t   vv;
        eff = tri_cnt > MAX_TRIANGLES ? MAX_TRIANGLES : tri_cnt;
        k   = $urandom_range(0, eff - 1);
        for (int c = 0; c < 3; c++)
            p[c] = 0;
        for (int j = 0; j < 3; j++) begin
            b  = k * VERTS_PER_TRI + j;
            vv = placed_vertex(b);
            p[0] += longint'(vv.x);
            p[1] += longint'(vv.y);
            p[2] += longint'(vv.z);
        end
        for (int c = 0; c < 3; c++) begin
            p[c] = p[c] / 3;
            o[c] = p[c] + $signed(rand_small(1 << 19));
            d[c] = (p[c] - o[c]) + $signed(rand_small(1 << 12));
        end
        return make_req(REQ_RAY, $urandom_range(0, 255), $urandom, $urandom, $urandom,
                        32'(o[0]), 32'(o[1]), 32'(o[2]),
                        32'(d[0]), 32'(d[1]), 32'(d[2]));
    endfunction

    function automatic req_t random_request();
        int p;
        p = $urandom_range(0, 99);
        if (p < 25)
            return make_req(REQ_LOAD, $urandom_range(0, 9) == 0 ? $urandom_range(SLOTS, 255)
                                                                 : $urandom_range(0, SLOTS - 1),
                            rand_coord(), rand_coord(), rand_coord(),
                            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (p < 75 && tri_cnt != 0)
            return aimed_ray();
        return make_req(REQ_RAY, $urandom_range(0, 255), $urandom, $urandom, $urandom,
                        rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord());
    endfunction

    // ---------------------------------------------------------------------
    // Bus tasks (called right after a rising edge)
    // ---------------------------------------------------------------------
    task automatic send_request(req_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall);
        track_request(r);
    endtask

    // Hold the sender until every expected result is back, then let the block settle.
    task automatic drain();
        req_valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_TRI_COUNT: tri_cnt = val[6:0];
            CFG_OFFSET_X:  off_x   = val;
            CFG_OFFSET_Y:  off_y   = val;
            default:       off_z   = val;
        endcase
    endtask

    task automatic set_scene(logic [6:0] cnt, logic [31:0] ox, logic [31:0] oy,
                             logic [31:0] oz);
        write_reg(CFG_TRI_COUNT, 32'(cnt));
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_OFFSET_Z, oz);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            send_request(random_request());
        drain();
    endtask

    task automatic report(string what, int got, int want);
        errors++;
        $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, want);
    endtask

    // ---------------------------------------------------------------------
    // Result side: stall pattern and checker
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_stall   <= 1'b0;
            stall_mode  <= 0;
            stall_timer <= 0;
            hold_left   <= 0;
            hold_ack    <= 0;
        end else if (hold_ack != hold_req) begin
            // Start a long hold-off asked for by the sender side.
            res_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_ack  <= hold_req;
        end else if (hold_left > 0) begin
            // Long hold-off: back the block up until it stalls its input.
            res_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            if (stall_timer == 0) begin
                stall_mode  <= $urandom_range(0, 3);
                stall_timer <= $urandom_range(100, 800);
            end else begin
                stall_timer <= stall_timer - 1;
            end
            case (stall_mode)
                0:       res_stall <= 1'b0;
                1:       res_stall <= ($urandom_range(0, 9) < 2);
                2:       res_stall <= ($urandom_range(0, 9) < 6);
                default: res_stall <= ($urandom_range(0, 199) == 0) ? 1'b1
                                    : (res_stall && $urandom_range(0, 29) != 0);
            endcase
        end
    end

    always @(posedge clk) begin
        res_t e;
        if (rst_n && res_valid && !res_stall) begin
            if (expected_hits.size() == 0) begin
                report("unexpected result, tri_index", res_data.tri_index, 0);
            end else begin
                e = expected_hits.pop_front();
                if (res_data.tri_index !== e.tri_index)
                    report("tri_index", res_data.tri_index, e.tri_index);
                if (res_data.hit !== e.hit)
                    report("hit", res_data.hit, e.hit);
                if (res_data.ray_param !== e.ray_param)
                    report("ray_param", res_data.ray_param, e.ray_param);
                if (res_data.parallel !== e.parallel)
                    report("parallel", res_data.parallel, e.parallel);
                if (res_data.last !== e.last)
                    report("last", res_data.last, e.last);
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        row_t rows [$];
        row_t w;
        clk       = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_TRI_COUNT;
        cfg_data  = '0;
        no_gaps   = 1'b0;
        tri_cnt   = 7'd1;
        off_x     = '0;
        off_y     = '0;
        off_z     = '0;
        for (int i = 0; i < SLOTS; i++) begin
            vx_mem[i] = '0;
            vy_mem[i] = '0;
            vz_mem[i] = '0;
        end

        // Directed table: unit right triangle in the z = 0 plane, default scene.
        w.typed = 0;
        w.e     = '0;
        w.r = make_req(REQ_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);          rows = {rows, w};
        w.r = make_req(REQ_LOAD, 1, Q_ONE, 0, 0, 0, 0, 0, 0, 0, 0);      rows = {rows, w};
        w.r = make_req(REQ_LOAD, 2, 0, Q_ONE, 0, 0, 0, 0, 0, 0, 0);      rows = {rows, w};
        w.typed = 1;
        // straight down onto the inside: hit at t = 1
        w.r = make_req(REQ_RAY, 0, 0, 0, 0, Q_QTR, Q_QTR, Q_ONE, 0, 0, Q_MONE);
        w.e = make_res(0, 1, Q_ONE, 0, 1);                               rows = {rows, w};
        // direction inside the plane: parallel
        w.r = make_req(REQ_RAY, 0, 0, 0, 0, Q_QTR, Q_QTR, Q_ONE, Q_ONE, 0, 0);
        w.e = make_res(0, 0, C_MAX, 1, 1);                               rows = {rows, w};
        // plane behind the origin still counts: t = -1
        w.r = make_req(REQ_RAY, 0, 0, 0, 0, Q_QTR, Q_QTR, Q_MONE, 0, 0, Q_MONE);
        w.e = make_res(0, 1, Q_MONE, 0, 1);                              rows = {rows, w};
        // outside the triangle
        w.r = make_req(REQ_RAY, 0, 0, 0, 0, 2 * Q_ONE, 2 * Q_ONE, Q_ONE, 0, 0, Q_MONE);
        w.e = make_res(0, 0, Q_ONE, 0, 1);                               rows = {rows, w};
        // exactly on an edge: not strictly inside
        w.r = make_req(REQ_RAY, 0, 0, 0, 0, 0, Q_QTR, Q_ONE, 0, 0, Q_MONE);
        w.e = make_res(0, 0, Q_ONE, 0, 1);                               rows = {rows, w};
        // tiny direction: t saturates high, then low
        w.r = make_req(REQ_RAY, 0, 0, 0, 0, Q_QTR, Q_QTR, Q_ONE, 0, 0, 32'hFFFF_FFFF);
        w.e = make_res(0, 1, C_MAX, 0, 1);                               rows = {rows, w};
        w.r = make_req(REQ_RAY, 0, 0, 0, 0, Q_QTR, Q_QTR, Q_MONE, 0, 0, 32'hFFFF_FFFF);
        w.e = make_res(0, 1, C_MIN, 0, 1);                               rows = {rows, w};
        w.typed = 0;
        // vertex fields ride along on a ray and are ignored
        w.r = make_req(REQ_RAY, 255, C_MIN, C_MAX, C_MIN, Q_QTR, Q_QTR, Q_ONE,
                       Q_QTR, Q_QTR, Q_MONE);                            rows = {rows, w};
        w.r = make_req(REQ_RAY, 0, 0, 0, 0, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        rows = {rows, w};
        w.r = make_req(REQ_RAY, 0, 0, 0, 0, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
        rows = {rows, w};
        // loads past the table are dropped
        w.r = make_req(REQ_LOAD, SLOTS, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0, 0, 0);
        rows = {rows, w};
        w.r = make_req(REQ_LOAD, 255, C_MIN, C_MIN, C_MIN, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom);                    rows = {rows, w};
        w.typed = 1;
        w.r = make_req(REQ_RAY, 0, 0, 0, 0, Q_QTR, Q_QTR, Q_ONE, 0, 0, Q_MONE);
        w.e = make_res(0, 1, Q_ONE, 0, 1);                               rows = {rows, w};
        w.typed = 0;
        // collapse the triangle to one extreme point: zero normal
        for (int j = 0; j < 3; j++) begin
            w.r = make_req(REQ_LOAD, j, C_MAX, C_MIN, C_MAX, 0, 0, 0, 0, 0, 0);
            rows = {rows, w};
        end
        w.typed = 1;
        w.r = make_req(REQ_RAY, 0, 0, 0, 0, 0, 0, 0, Q_ONE, Q_ONE, Q_ONE);
        w.e = make_res(0, 0, C_MAX, 1, 1);                               rows = {rows, w};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) begin
            if (rows[i].typed) begin
                // Take the typed-in result instead of the predicted one.
                send_request(make_req(REQ_LOAD, SLOTS, 0, 0, 0, 0, 0, 0, 0, 0, 0));
                req_valid <= 1'b1;
                req_data  <= rows[i].r;
                do
                    @(posedge clk);
                while (req_stall);
                expected_hits = {expected_hits, rows[i].e};
            end else begin
                send_request(rows[i].r);
            end
        end
        drain();

        // Fill the whole vertex table so any triangle count reads loaded slots only.
        no_gaps = 1'b1;
        for (int s = 0; s < SLOTS; s++)
            send_request(make_req(REQ_LOAD, s, rand_coord(), rand_coord(), rand_coord(),
                                  0, 0, 0, 0, 0, 0));
        no_gaps = 1'b0;
        drain();

        set_scene(7'd3, 0, 0, 0);
        random_phase(20);

        // Zero triangles: rays produce nothing.
        set_scene(7'd0, rand_small(1 << 18), rand_small(1 << 18), rand_small(1 << 18));
        random_phase(8);

        // Count above the table saturates; hold the receiver off for a long stretch.
        set_scene(7'd127, rand_small(1 << 16), rand_small(1 << 16), rand_small(1 << 16));
        hold_req++;
        for (int i = 0; i < 3; i++)
            send_request(aimed_ray());
        drain();

        set_scene(7'd1, C_MAX, C_MIN, C_MAX);
        random_phase(15);

        set_scene(7'd64, C_MIN, C_MAX, C_MIN);
        random_phase(3);

        for (int p = 0; p < 3; p++) begin
            set_scene(7'($urandom_range(1, 8)), rand_coord(), rand_coord(), rand_coord());
            random_phase(7);
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
